/* rtl/jsesc_pkg.sv */
// ----------------------------------------------------------------------------
// jsesc_pkg
// Shared types, constants and helper functions for the JSON string escaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsesc_pkg;

    localparam int CMD_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    // character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_HEX_AF = 8'h57;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CTL_LIMIT = 8'h20;

    // replacement character EF BF BD
    localparam logic [7:0] REPL_0 = 8'hEF;
    localparam logic [7:0] REPL_1 = 8'hBF;
    localparam logic [7:0] REPL_2 = 8'hBD;

    // body kinds of one command
    localparam logic [2:0] BODY_NONE = 3'd0;
    localparam logic [2:0] BODY_BYTE = 3'd1;
    localparam logic [2:0] BODY_ESC  = 3'd2;
    localparam logic [2:0] BODY_UESC = 3'd3;
    localparam logic [2:0] BODY_BAD  = 3'd4;
    localparam logic [2:0] BODY_SEQ  = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_first;
        logic       is_last;
    } jsesc_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } jsesc_result_t;

    // one classified request, handed from front to back
    typedef struct packed {
        logic            open_q;
        logic [1:0]      pre_bad;
        logic [2:0]      body_kind;
        logic [2:0]      body_len;
        logic [3:0][7:0] body;
        logic [1:0]      post_bad;
        logic            close_q;
    } jsesc_cmd_t;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (CH_ZERO + {4'b0, n}) : (CH_HEX_AF + {4'b0, n});
    endfunction

    function automatic logic [3:0] times3(input logic [1:0] n);
        return {1'b0, n, 1'b0} + {2'b0, n};
    endfunction

    // replacement byte at position m of a run of triples, m below 9
    function automatic logic [7:0] repl_at(input logic [4:0] m);
        logic [1:0] r;
        r = 2'd0;
        case (m)
            5'd0, 5'd3, 5'd6: r = 2'd0;
            5'd1, 5'd4, 5'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return (r == 2'd0) ? REPL_0 : ((r == 2'd1) ? REPL_1 : REPL_2);
    endfunction

endpackage

`default_nettype wire

/* rtl/jsesc_fifo.sv */
// ----------------------------------------------------------------------------
// jsesc_fifo
// Small register queue with full/empty flags, used between the stages.
// ----------------------------------------------------------------------------
`default_nettype none

module jsesc_fifo #(
    parameter int  DEPTH = 2,
    parameter type T     = logic
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  T          wdata,
    output logic      full,
    input  wire logic pop,
    output T          rdata,
    output logic      empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T              mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

/* rtl/jsesc_front.sv */
// ----------------------------------------------------------------------------
// jsesc_front
// Classifies each input byte, tracks the pending UTF-8 sequence and builds
// one command per request.
// ----------------------------------------------------------------------------
`default_nettype none

module jsesc_front
    import jsesc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  accept,
    input  jsesc_item_t item,
    output jsesc_cmd_t  cmd
);

    logic [7:0] lead_reg, lead_next;
    logic [7:0] cont0_reg, cont0_next;
    logic [7:0] cont1_reg, cont1_next;
    logic [1:0] exp_reg, exp_next;
    logic [1:0] held_reg, held_next;
    logic [7:0] c;
    logic       esc_hit;
    logic [7:0] esc_char;

    assign c = item.data_byte;

    always_comb
    begin
        esc_hit  = 1'b1;
        esc_char = CH_N;
        case (c)
            8'h0A:     esc_char = CH_N;
            8'h0D:     esc_char = CH_R;
            8'h09:     esc_char = CH_T;
            8'h08:     esc_char = CH_B;
            8'h0C:     esc_char = CH_F;
            CH_BSLASH: esc_char = CH_BSLASH;
            CH_QUOTE:  esc_char = CH_QUOTE;
            default:   esc_hit  = 1'b0;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        lead_next  = lead_reg;
        cont0_next = cont0_reg;
        cont1_next = cont1_reg;
        exp_next   = exp_reg;
        held_next  = held_reg;
        if (accept)
        begin
            cmd.open_q  = item.is_first;
            cmd.close_q = item.is_last;
            if (item.is_first)
            begin
                exp_next  = 2'd0;
                held_next = 2'd0;
            end
            if (item.has_byte)
            begin
                if (exp_next != 2'd0 && c[7:6] == 2'b10)
                begin
                    if ({1'b0, held_next} + 3'd1 >= {1'b0, exp_next})
                    begin
                        // sequence complete: pass all of it through
                        cmd.body_kind = BODY_SEQ;
                        cmd.body_len  = {1'b0, held_next} + 3'd2;
                        cmd.body[0]   = lead_reg;
                        cmd.body[1]   = (held_next >= 2'd1) ? cont0_reg : c;
                        cmd.body[2]   = (held_next >= 2'd2) ? cont1_reg : c;
                        cmd.body[3]   = c;
                        exp_next      = 2'd0;
                        held_next     = 2'd0;
                    end
                    else
                    begin
                        if (held_next[0])
                        begin
                            cont1_next = c;
                        end
                        else
                        begin
                            cont0_next = c;
                        end
                        held_next = held_next + 2'd1;
                    end
                end
                else
                begin
                    // no sequence continues: replace any held bytes, then classify afresh
                    if (exp_next != 2'd0)
                    begin
                        cmd.pre_bad = held_next + 2'd1;
                        exp_next    = 2'd0;
                        held_next   = 2'd0;
                    end
                    cmd.body[0] = c;
                    if (esc_hit)
                    begin
                        cmd.body_kind = BODY_ESC;
                        cmd.body_len  = 3'd2;
                        cmd.body[0]   = esc_char;
                    end
                    else if (c < CTL_LIMIT)
                    begin
                        cmd.body_kind = BODY_UESC;
                        cmd.body_len  = 3'd6;
                    end
                    else if (!c[7])
                    begin
                        cmd.body_kind = BODY_BYTE;
                        cmd.body_len  = 3'd1;
                    end
                    else if (c[7:5] == 3'b110)
                    begin
                        lead_next = c;
                        exp_next  = 2'd1;
                    end
                    else if (c[7:4] == 4'b1110)
                    begin
                        lead_next = c;
                        exp_next  = 2'd2;
                    end
                    else if (c[7:3] == 5'b11110)
                    begin
                        lead_next = c;
                        exp_next  = 2'd3;
                    end
                    else
                    begin
                        cmd.body_kind = BODY_BAD;
                        cmd.body_len  = 3'd3;
                    end
                end
            end
            if (item.is_last && exp_next != 2'd0)
            begin
                cmd.post_bad = held_next + 2'd1;
                exp_next     = 2'd0;
                held_next    = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg <= '0;
            exp_reg  <= '0;
            held_reg <= '0;
        end
        else
        begin
            lead_reg <= lead_next;
            exp_reg  <= exp_next;
            held_reg <= held_next;
        end
    end

    // continuation bytes are only read once written
    always_ff @(posedge clk)
    begin
        cont0_reg <= cont0_next;
        cont1_reg <= cont1_next;
    end

endmodule

`default_nettype wire

/* rtl/jsesc_back.sv */
// ----------------------------------------------------------------------------
// jsesc_back
// Expands a command into its output bytes, one byte per cycle unless out_full.
// ----------------------------------------------------------------------------
`default_nettype none

module jsesc_back
    import jsesc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cmd_valid,
    input  jsesc_cmd_t   cmd,
    output logic         cmd_pop,
    input  wire logic    out_full,
    output logic         out_push,
    output jsesc_result_t out_data
);

    logic [3:0] idx_reg, idx_next;
    logic [4:0] idx;
    logic [4:0] o1, o2, o3, o4, total;
    logic [4:0] j;
    logic       at_end;
    logic [7:0] body_byte;

    assign idx   = {1'b0, idx_reg};
    assign o1    = {4'b0, cmd.open_q};
    assign o2    = o1 + {1'b0, times3(cmd.pre_bad)};
    assign o3    = o2 + {2'b0, cmd.body_len};
    assign o4    = o3 + {1'b0, times3(cmd.post_bad)};
    assign total = o4 + {4'b0, cmd.close_q};
    assign j     = idx - o2;
    assign at_end = (idx + 5'd1 == total);

    always_comb
    begin
        body_byte = cmd.body[0];
        case (cmd.body_kind)
            BODY_ESC:
            begin
                body_byte = (j == 5'd0) ? CH_BSLASH : cmd.body[0];
            end
            BODY_UESC:
            begin
                case (j)
                    5'd0:    body_byte = CH_BSLASH;
                    5'd1:    body_byte = CH_U;
                    5'd2:    body_byte = CH_ZERO;
                    5'd3:    body_byte = CH_ZERO;
                    5'd4:    body_byte = hex_char(cmd.body[0][7:4]);
                    default: body_byte = hex_char(cmd.body[0][3:0]);
                endcase
            end
            BODY_BAD:
            begin
                body_byte = repl_at(j);
            end
            BODY_SEQ:
            begin
                body_byte = cmd.body[j[1:0]];
            end
            default:
            begin
                body_byte = cmd.body[0];
            end
        endcase
    end

    always_comb
    begin
        out_data = '0;
        if (idx < o1)
        begin
            out_data.out_byte = CH_QUOTE;
        end
        else if (idx < o2)
        begin
            out_data.out_byte = repl_at(idx - o1);
        end
        else if (idx < o3)
        begin
            out_data.out_byte = body_byte;
        end
        else if (idx < o4)
        begin
            out_data.out_byte = repl_at(idx - o3);
        end
        else
        begin
            out_data.out_byte = CH_QUOTE;
            out_data.out_last = 1'b1;
        end
    end

    always_comb
    begin
        out_push = cmd_valid && (total != 5'd0) && !out_full;
        cmd_pop  = cmd_valid && ((total == 5'd0) || (out_push && at_end));
        idx_next = idx_reg;
        if (cmd_pop)
        begin
            idx_next = '0;
        end
        else if (out_push)
        begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/json_string_escape_utf8_check_core.sv */
// A result byte passes the command queue and then the output queue before it
// shows on the result ports, when nothing ahead of it is waiting.
// Throughput: one request per cycle while each yields at most one byte and
// the output queue has room; N-byte requests (up to 16) hold the sequencer.
// Reset: rst_n clears both queues and any pending UTF-8 sequence at once.
// ----------------------------------------------------------------------------
// json_string_escape_utf8_check_core
// JSON string literal encoder with UTF-8 sequence checking and repair.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_escape_utf8_check_core
    import jsesc_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  jsesc_item_t   item,
    input  wire logic     push,
    output logic          full,
    output jsesc_result_t result,
    output logic          empty,
    input  wire logic     pop
);

    jsesc_cmd_t    front_cmd;
    jsesc_cmd_t    back_cmd;
    logic          accept;
    logic          cmd_empty;
    logic          cmd_pop;
    logic          out_full;
    logic          out_push;
    jsesc_result_t out_data;

    assign accept = push && !full;

    jsesc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cmd    (front_cmd)
    );

    jsesc_fifo #(
        .DEPTH (CMD_DEPTH),
        .T     (jsesc_cmd_t)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (front_cmd),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (back_cmd),
        .empty (cmd_empty)
    );

    jsesc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (back_cmd),
        .cmd_pop   (cmd_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_data  (out_data)
    );

    jsesc_fifo #(
        .DEPTH (OUT_DEPTH),
        .T     (jsesc_result_t)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_data),
        .full  (out_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

`default_nettype wire

/* rtl/jsesc_checker.sv */
// ----------------------------------------------------------------------------
// jsesc_checker
// Port-level checks on the escaper top level, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module jsesc_checker
    import jsesc_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input jsesc_item_t  item,
    input wire logic    push,
    input wire logic    full,
    input jsesc_result_t result,
    input wire logic    empty,
    input wire logic    pop
);

    // reset leaves no result waiting
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result queue not empty after reset");

    // reset leaves room for a request
    a_reset_room: assert property (@(posedge clk) !rst_n |=> !full)
        else $error("request queue full after reset");

    // the end-of-string flag only marks a closing quote
    a_last_is_quote: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.out_last) |-> (result.out_byte == CH_QUOTE))
        else $error("out_last on a byte that is not a quote");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

endmodule

bind json_string_escape_utf8_check_core jsesc_checker u_jsesc_checker (.*);

`default_nettype wire

/* dv/json_string_escape_utf8_check_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_escape_utf8_check_core_test
// Drives strings of raw bytes into the JSON string escaper and checks every
// output byte against a behavioral encoder kept in step with the accepted
// requests. Directed strings cover escapes, control bytes and UTF-8 repair.
// Random strings are mostly well-formed text, mixed with noise. The traffic
// runs under several idle and stall mixes on both sides.
// ----------------------------------------------------------------------------

module json_string_escape_utf8_check_core_test;
    import jsesc_pkg::*;

    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] HEX_A    = 8'h61;
    localparam int RANDOM_PER_PHASE = 70;
    localparam int PRINT_LIMIT      = 40;

    logic          clk = 1'b0;
    logic          rst_n = 1'b1;
    jsesc_item_t   item = '0;
    logic          push = 1'b0;
    logic          full;
    jsesc_result_t result;
    logic          empty;
    logic          pop = 1'b0;

    jsesc_item_t   pending_items[$];
    jsesc_result_t expected_out[$];
    int            items_queued = 0;
    int            items_counted = 0;
    int            items_accepted = 0;
    int            results_seen = 0;
    int            mismatch_count = 0;
    int            send_idle_pct = 0;
    int            pop_stall_pct = 0;
    logic          item_taken = 1'b0;

    // encoder state
    logic [7:0]    held_lead = '0;
    logic [7:0]    held_cont[2] = '{8'h00, 8'h00};
    logic [1:0]    cont_needed = '0;
    logic [1:0]    cont_held = '0;

    json_string_escape_utf8_check_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .push   (push),
        .full   (full),
        .result (result),
        .empty  (empty),
        .pop    (pop)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------- encoder

    function automatic void emit(input logic [7:0] b, input logic last);
        jsesc_result_t r;
        r.out_byte = b;
        r.out_last = last;
        expected_out.push_back(r);
    endfunction

    function automatic void emit_repl();
        emit(REPL_0, 1'b0);
        emit(REPL_1, 1'b0);
        emit(REPL_2, 1'b0);
    endfunction

    function automatic void flush_held_repl();
        if (cont_needed == 2'd0)
            return;
        emit_repl();
        for (int i = 0; i < cont_held && i < 2; i++)
            emit_repl();
        cont_needed = 2'd0;
        cont_held = 2'd0;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        return (n < 4'd10) ? CH_ZERO + 8'(n) : HEX_A + 8'(n) - 8'd10;
    endfunction

    function automatic void encode_fresh(input logic [7:0] c);
        case (c)
            BYTE_LF:   begin emit(CH_BSLASH, 1'b0); emit(CH_N, 1'b0); return; end
            BYTE_CR:   begin emit(CH_BSLASH, 1'b0); emit(CH_R, 1'b0); return; end
            BYTE_TAB:  begin emit(CH_BSLASH, 1'b0); emit(CH_T, 1'b0); return; end
            BYTE_BS:   begin emit(CH_BSLASH, 1'b0); emit(CH_B, 1'b0); return; end
            BYTE_FF:   begin emit(CH_BSLASH, 1'b0); emit(CH_F, 1'b0); return; end
            CH_BSLASH: begin emit(CH_BSLASH, 1'b0); emit(CH_BSLASH, 1'b0); return; end
            CH_QUOTE:  begin emit(CH_BSLASH, 1'b0); emit(CH_QUOTE, 1'b0); return; end
            default: ;
        endcase
        if (c < CTL_LIMIT) begin
            emit(CH_BSLASH, 1'b0);
            emit(CH_U, 1'b0);
            emit(CH_ZERO, 1'b0);
            emit(CH_ZERO, 1'b0);
            emit(hex_digit(c[7:4]), 1'b0);
            emit(hex_digit(c[3:0]), 1'b0);
        end else if (c[7] == 1'b0) begin
            emit(c, 1'b0);
        end else if (c[7:5] == 3'b110) begin
            held_lead = c; cont_needed = 2'd1; cont_held = 2'd0;
        end else if (c[7:4] == 4'b1110) begin
            held_lead = c; cont_needed = 2'd2; cont_held = 2'd0;
        end else if (c[7:3] == 5'b11110) begin
            held_lead = c; cont_needed = 2'd3; cont_held = 2'd0;
        end else begin
            emit_repl();
        end
    endfunction

    function automatic void encode_byte(input logic [7:0] c);
        if (cont_needed != 2'd0) begin
            if (c[7:6] == 2'b10) begin
                if (int'(cont_held) + 1 >= int'(cont_needed)) begin
                    emit(held_lead, 1'b0);
                    for (int i = 0; i < cont_held && i < 2; i++)
                        emit(held_cont[i], 1'b0);
                    emit(c, 1'b0);
                    cont_needed = 2'd0;
                    cont_held = 2'd0;
                end else begin
                    held_cont[cont_held[0]] = c;
                    cont_held = cont_held + 2'd1;
                end
                return;
            end
            flush_held_repl();
        end
        encode_fresh(c);
    endfunction

    function automatic void predict_literal(input jsesc_item_t it);
        if (it.is_first) begin
            // a new string drops any unfinished sequence without repair
            cont_needed = 2'd0;
            cont_held = 2'd0;
            emit(CH_QUOTE, 1'b0);
        end
        if (it.has_byte)
            encode_byte(it.data_byte);
        if (it.is_last) begin
            flush_held_repl();
            emit(CH_QUOTE, 1'b1);
        end
    endfunction

    // --------------------------------------------------------------- stimulus

    task automatic add_item(input logic [7:0] data, input logic has, input logic first,
                            input logic last);
        jsesc_item_t it;
        it.data_byte = data;
        it.has_byte = has;
        it.is_first = first;
        it.is_last = last;
        pending_items.push_back(it);
        items_queued++;
        if (has || first || last)
            items_counted++;
    endtask

    task automatic add_string(input logic [7:0] text[$]);
        for (int i = 0; i < text.size(); i++)
            add_item(text[i], 1'b1, i == 0, i == text.size() - 1);
    endtask

    function automatic logic [7:0] utf8_lead(input int n_cont);
        case (n_cont)
            1:       return 8'hC0 | 8'($urandom_range(31));
            2:       return 8'hE0 | 8'($urandom_range(15));
            default: return 8'hF0 | 8'($urandom_range(7));
        endcase
    endfunction

    function automatic logic [7:0] utf8_cont();
        return 8'h80 | 8'($urandom_range(63));
    endfunction

    task automatic queue_random_string();
        logic [7:0] text[$];
        int n_chars;
        int kind;
        int n_cont;
        int close_mode;
        n_chars = $urandom_range(10);
        close_mode = $urandom_range(99);
        if (n_chars == 0) begin
            add_item(8'($urandom), 1'b0, 1'b1, 1'b1);
            return;
        end
        for (int k = 0; k < n_chars; k++) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                text.push_back(8'($urandom_range(8'h20, 8'h7F)));
            end else if (kind < 45) begin
                case ($urandom_range(6))
                    0: text.push_back(BYTE_LF);
                    1: text.push_back(BYTE_CR);
                    2: text.push_back(BYTE_TAB);
                    3: text.push_back(BYTE_BS);
                    4: text.push_back(BYTE_FF);
                    5: text.push_back(CH_BSLASH);
                    default: text.push_back(CH_QUOTE);
                endcase
            end else if (kind < 52) begin
                text.push_back(8'($urandom_range(8'h1F)));
            end else if (kind < 82) begin
                n_cont = $urandom_range(1, 3);
                text.push_back(utf8_lead(n_cont));
                for (int j = 0; j < n_cont; j++)
                    text.push_back(utf8_cont());
            end else if (kind < 88) begin
                text.push_back(8'hF8 | 8'($urandom_range(7)));
            end else if (kind < 93) begin
                text.push_back(utf8_cont());
            end else begin
                // sequence cut short; what follows usually breaks it or ends the string
                n_cont = $urandom_range(1, 3);
                text.push_back(utf8_lead(n_cont));
                for (int j = 0; j < $urandom_range(n_cont - 1); j++)
                    text.push_back(utf8_cont());
            end
        end
        for (int i = 0; i < text.size(); i++) begin
            if (i != 0 && $urandom_range(99) < 5)
                add_item(8'($urandom), 1'b0, 1'b0, 1'b0);
            if ($urandom_range(99) < 3)
                add_item(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
            add_item(text[i], 1'b1, i == 0,
                     i == text.size() - 1 && close_mode >= 13);
        end
        // close on a byteless request, unless the last byte closed it or the string is left open
        if (close_mode < 8)
            add_item(8'($urandom), 1'b0, 1'b0, 1'b1);
    endtask

    task automatic wait_all_accepted();
        while (items_accepted != items_queued)
            @(posedge clk);
    endtask

    task automatic run_random_phase(input int send_pct, input int stall_pct);
        int target;
        send_idle_pct = send_pct;
        pop_stall_pct = stall_pct;
        target = items_counted + RANDOM_PER_PHASE;
        while (items_counted < target)
            queue_random_string();
        wait_all_accepted();
    endtask

    // ---------------------------------------------------------------- driver

    always @(negedge clk)
    begin : drive_requests
        if (!rst_n) begin
            push <= 1'b0;
            pop <= 1'b0;
        end else begin
            if (!push || item_taken) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item <= pending_items.pop_front();
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk)
    begin : watch_ports
        jsesc_result_t want;
        if (!rst_n) begin
            item_taken <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_out.size() == 0) begin
                    report_mismatch($sformatf("result %0d (%h, last %b) with none expected",
                                              results_seen, result.out_byte,
                                              result.out_last));
                end else begin
                    want = expected_out.pop_front();
                    if (result.out_byte !== want.out_byte)
                        report_mismatch($sformatf("result %0d out_byte %h, expected %h",
                                                  results_seen, result.out_byte,
                                                  want.out_byte));
                    if (result.out_last !== want.out_last)
                        report_mismatch($sformatf("result %0d out_last %b, expected %b",
                                                  results_seen, result.out_last,
                                                  want.out_last));
                end
                results_seen++;
            end
            if (push && !full) begin
                predict_literal(item);
                items_accepted++;
            end
            item_taken <= push && !full;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        // a real falling edge so the asynchronous reset takes effect
        #1 rst_n = 1'b0;
        repeat (4) @(posedge clk);
        #1 rst_n = 1'b1;

        // empty string, data ignored
        add_item(8'hA5, 1'b0, 1'b1, 1'b1);
        // escapes, control bytes, bad lead at the top of the range
        add_string('{8'h00, BYTE_LF, BYTE_CR, BYTE_TAB, BYTE_BS, BYTE_FF, CH_BSLASH,
                     CH_QUOTE, 8'h1F, 8'hFF});
        // complete 2/3/4-byte forms, stray continuation, broken and truncated forms
        add_string('{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
                     8'h80, 8'hE2, 8'h41, 8'hF0, 8'h9F, 8'h98});
        // new string while a sequence is held
        add_item(8'hE2, 1'b1, 1'b1, 1'b0);
        add_item(8'h42, 1'b1, 1'b1, 1'b1);
        wait_all_accepted();

        run_random_phase(0, 0);
        run_random_phase(54, 0);
        run_random_phase(0, 54);
        run_random_phase(14, 14);

        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
rtl/jsesc_pkg.sv
rtl/jsesc_fifo.sv
rtl/jsesc_front.sv
rtl/jsesc_back.sv
rtl/json_string_escape_utf8_check_core.sv
rtl/jsesc_checker.sv
dv/json_string_escape_utf8_check_core_test.sv
